FILE: design/rsit_pkg.sv
// package for the refcounted share id table: payload structs, status codes
// and the controller/datapath command and status structs; no dependencies
package rsit_pkg;
	localparam int DEPTH_DEFAULT = 64;
	localparam logic [31:0] ID_STEP = 32'd2;
	localparam logic [31:0] REFS_MAX = 32'hFFFF_FFFF;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_MATCH = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_WRAP = 2'd3;

	localparam logic OP_CREATE = 1'b0;
	localparam logic OP_REDEEM = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [31:0] buffer_handle;
		logic [31:0] access_flags;
		logic [63:0] endpoint_vuid;
		logic [31:0] share_id_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] share_id_out;
		logic [31:0] handle_out;
		logic        entry_freed;
	} out_item_t;

	typedef struct packed {
		logic load;      // capture input item, clear scan state
		logic scan_rd;   // issue memory read at scan index
		logic scan_chk;  // compare registered read data
		logic commit;    // apply update, form result
	} cmd_t;

	typedef struct packed {
		logic scan_last; // read issued for final index
	} sts_t;
endpackage

FILE: design/rsit_datapath.sv
// datapath of the share id table: slot memories, valid bits, freed id fifo,
// id counter and the scan compare; uses rsit_pkg
module rsit_datapath #(
	parameter int TABLE_DEPTH = rsit_pkg::DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rsit_pkg::in_item_t  item,
	input  rsit_pkg::cmd_t      cmd,
	output rsit_pkg::sts_t      sts,
	output rsit_pkg::out_item_t result
);
	import rsit_pkg::*;
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW:0] DEPTH_W = {1'b0, DEPTH_C};

	logic [31:0] mem_id [TABLE_DEPTH];
	logic [31:0] mem_handle [TABLE_DEPTH];
	logic [31:0] mem_flags [TABLE_DEPTH];
	logic [63:0] mem_vuid [TABLE_DEPTH];
	logic [31:0] mem_refs [TABLE_DEPTH];
	logic [31:0] fifo_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	in_item_t    item_q;
	logic [IW-1:0] rd_idx_q, chk_idx_q;
	logic [31:0] rd_id_q, rd_handle_q, rd_flags_q, rd_refs_q;
	logic [63:0] rd_vuid_q;
	logic        hit_q, free_found_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	logic [31:0] hit_id_q, hit_handle_q, hit_flags_q, hit_refs_q;
	logic [63:0] hit_vuid_q;
	logic [CW-1:0] freed_count_q;
	logic [IW-1:0] fifo_head_q;
	logic [31:0] fifo_rd_q;
	logic [31:0] id_counter_q;

	logic        match;
	logic [31:0] next_ctr;
	logic [CW:0] tail_sum;
	logic [IW-1:0] tail;
	logic        do_write, do_refs, do_free, do_alloc_fifo, do_alloc_ctr;
	logic [31:0] new_refs, new_id;
	logic [IW-1:0] wr_idx;
	out_item_t   res;

	assign sts.scan_last = (rd_idx_q == LAST);

	always_comb begin
		if (item_q.operation == OP_CREATE)
			match = valid_q[chk_idx_q] && rd_handle_q == item_q.buffer_handle &&
				rd_flags_q == item_q.access_flags && rd_vuid_q == item_q.endpoint_vuid;
		else
			match = valid_q[chk_idx_q] && rd_id_q == item_q.share_id_in;
	end

	assign next_ctr = id_counter_q + ID_STEP;
	// fifo tail wraps by one compare and subtract
	assign tail_sum = {1'b0, CW'(fifo_head_q)} + {1'b0, freed_count_q};
	assign tail = (tail_sum >= DEPTH_W) ? IW'(tail_sum - DEPTH_W) : IW'(tail_sum);

	// commit decisions
	always_comb begin
		do_write = 1'b0;
		do_refs = 1'b0;
		do_free = 1'b0;
		do_alloc_fifo = 1'b0;
		do_alloc_ctr = 1'b0;
		new_refs = hit_refs_q;
		new_id = fifo_rd_q;
		wr_idx = free_idx_q;
		res = '0;
		if (item_q.operation == OP_CREATE) begin
			if (hit_q) begin
				res.status = ST_OK;
				res.share_id_out = hit_id_q;
				do_refs = hit_refs_q != REFS_MAX;
				new_refs = hit_refs_q + 32'd1;
				wr_idx = hit_idx_q;
			end else if (!free_found_q) begin
				res.status = ST_FULL;
			end else if (freed_count_q != '0) begin
				do_alloc_fifo = 1'b1;
				do_write = 1'b1;
				res.status = ST_OK;
				res.share_id_out = fifo_rd_q;
			end else if (next_ctr == 32'd0) begin
				res.status = ST_WRAP;
			end else begin
				do_alloc_ctr = 1'b1;
				do_write = 1'b1;
				new_id = next_ctr;
				res.status = ST_OK;
				res.share_id_out = next_ctr;
			end
		end else begin
			wr_idx = hit_idx_q;
			if (!hit_q || hit_vuid_q != item_q.endpoint_vuid ||
				hit_flags_q != item_q.access_flags) begin
				res.status = ST_NO_MATCH;
			end else begin
				res.status = ST_OK;
				res.handle_out = hit_handle_q;
				do_refs = 1'b1;
				if (hit_refs_q > 32'd1) begin
					new_refs = hit_refs_q - 32'd1;
				end else begin
					new_refs = 32'd0;
					do_free = 1'b1;
					res.entry_freed = 1'b1;
				end
			end
		end
	end

	// slot memories: one read port at the scan index, one write port at commit
	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rd_id_q <= mem_id[rd_idx_q];
			rd_handle_q <= mem_handle[rd_idx_q];
			rd_flags_q <= mem_flags[rd_idx_q];
			rd_vuid_q <= mem_vuid[rd_idx_q];
			rd_refs_q <= mem_refs[rd_idx_q];
		end
		if (cmd.commit && do_write) begin
			mem_id[wr_idx] <= new_id;
			mem_handle[wr_idx] <= item_q.buffer_handle;
			mem_flags[wr_idx] <= item_q.access_flags;
			mem_vuid[wr_idx] <= item_q.endpoint_vuid;
			mem_refs[wr_idx] <= 32'd1;
		end else if (cmd.commit && do_refs) begin
			mem_refs[wr_idx] <= new_refs;
		end
		if (cmd.commit && do_free && freed_count_q < DEPTH_C)
			fifo_mem[tail] <= hit_id_q;
		fifo_rd_q <= fifo_mem[fifo_head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.scan_rd) chk_idx_q <= rd_idx_q;
		if (cmd.scan_chk && match && !hit_q) begin
			hit_idx_q <= chk_idx_q;
			hit_id_q <= rd_id_q;
			hit_handle_q <= rd_handle_q;
			hit_flags_q <= rd_flags_q;
			hit_vuid_q <= rd_vuid_q;
			hit_refs_q <= rd_refs_q;
		end
		if (cmd.scan_chk && !valid_q[chk_idx_q] && !free_found_q)
			free_idx_q <= chk_idx_q;
		if (cmd.commit) result <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_idx_q <= '0;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
			freed_count_q <= '0;
			fifo_head_q <= '0;
			id_counter_q <= '0;
		end else begin
			if (cmd.load) begin
				rd_idx_q <= '0;
				hit_q <= 1'b0;
				free_found_q <= 1'b0;
			end else if (cmd.scan_rd && rd_idx_q != LAST) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
			if (cmd.scan_chk && match) hit_q <= 1'b1;
			if (cmd.scan_chk && !valid_q[chk_idx_q]) free_found_q <= 1'b1;
			if (cmd.commit) begin
				if (do_write) valid_q[wr_idx] <= 1'b1;
				if (do_free) valid_q[wr_idx] <= 1'b0;
				if (do_alloc_ctr) id_counter_q <= next_ctr;
				if (do_alloc_fifo) begin
					fifo_head_q <= (fifo_head_q == LAST) ? '0 : fifo_head_q + IW'(1);
					freed_count_q <= freed_count_q - CW'(1);
				end else if (do_free && freed_count_q < DEPTH_C) begin
					freed_count_q <= freed_count_q + CW'(1);
				end
			end
		end
	end
endmodule

FILE: design/rsit_ctrl.sv
// controller of the share id table: accept, scan, commit, deliver sequence
// uses rsit_pkg
module rsit_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rsit_pkg::sts_t    sts,
	output rsit_pkg::cmd_t    cmd
);
	import rsit_pkg::*;
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_LAST = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic       chk_q;
	logic       out_valid_q;

	// a new item may enter once the old result is taken or being taken
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.scan_rd = (state_q == S_SCAN);
		cmd.scan_chk = chk_q;
		cmd.commit = (state_q == S_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chk_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			chk_q <= cmd.scan_rd;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_last) state_q <= S_LAST;
				S_LAST: state_q <= S_DONE; // wait for last compare
				S_DONE: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: design/refcounted_share_id_table.sv
// top level of the reference counted share id table
// joins rsit_ctrl and rsit_datapath; uses rsit_pkg
//
// usage: one input channel (in_valid/in_ready/in_item) carries create or
// redeem items, one output channel (out_valid/out_ready/out_item) returns
// exactly one result item per input item, in order.
// operation: an item scans every slot through the one read port of the slot
// memory, one slot a cycle, then passes the S_LAST compare state and the
// S_DONE commit state before out_valid rises; one item is worked on at a
// time, so no new item is accepted before the previous one has its result.
// the result sits in an output register; the next item is accepted while
// that result is being taken, and the block waits in idle while the
// receiver stalls with a result pending.
// reset clears the valid bits, the freed id count, the fifo head and the id
// counter at once; no clearing pass is needed and the first item can be taken
// as soon as reset is released.
module refcounted_share_id_table #(
	parameter int TABLE_DEPTH = rsit_pkg::DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rsit_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output rsit_pkg::out_item_t out_item
);
	import rsit_pkg::*;
	cmd_t cmd;
	sts_t sts;

	rsit_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	rsit_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(in_item), .cmd(cmd), .sts(sts),
		.result(out_item)
	);
endmodule

FILE: tb/testbench.sv
// testbench for refcounted_share_id_table: directed and random create/redeem
// items checked against a behavioral copy of the share id table; uses rsit_pkg
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rsit_pkg::*;

	localparam int DEPTH = 64;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	refcounted_share_id_table #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	// behavioral table state
	logic        tbl_valid [DEPTH];
	logic [31:0] tbl_id [DEPTH];
	logic [31:0] tbl_handle [DEPTH];
	logic [31:0] tbl_flags [DEPTH];
	logic [63:0] tbl_vuid [DEPTH];
	logic [31:0] tbl_refs [DEPTH];
	logic [31:0] freed_ids [$];
	logic [31:0] last_counter_id;

	in_item_t  pending_items [$];
	out_item_t awaited_results [$];
	int errors, sent, received, n_full, n_freed, n_nomatch, n_hits;

	function automatic out_item_t share_table_predict(in_item_t it);
		out_item_t r;
		int free_slot;
		int hit;
		logic [31:0] id;
		r = '0;
		free_slot = -1;
		hit = -1;
		if (it.operation == OP_CREATE) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (tbl_valid[i]) begin
					if (hit < 0 && tbl_handle[i] == it.buffer_handle &&
							tbl_flags[i] == it.access_flags && tbl_vuid[i] == it.endpoint_vuid)
						hit = i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (hit >= 0) begin
				if (tbl_refs[hit] != REFS_MAX)
					tbl_refs[hit]++;
				r.share_id_out = tbl_id[hit];
				n_hits++;
				return r;
			end
			if (free_slot < 0) begin
				r.status = ST_FULL;
				n_full++;
				return r;
			end
			if (freed_ids.size() != 0) begin
				id = freed_ids.pop_front();
			end else begin
				id = last_counter_id + ID_STEP;
				if (id == 0) begin
					r.status = ST_WRAP;
					return r;
				end
				last_counter_id = id;
			end
			tbl_valid[free_slot] = 1'b1;
			tbl_id[free_slot] = id;
			tbl_handle[free_slot] = it.buffer_handle;
			tbl_flags[free_slot] = it.access_flags;
			tbl_vuid[free_slot] = it.endpoint_vuid;
			tbl_refs[free_slot] = 32'd1;
			r.share_id_out = id;
		end else begin
			for (int i = 0; i < DEPTH; i++)
				if (hit < 0 && tbl_valid[i] && tbl_id[i] == it.share_id_in)
					hit = i;
			if (hit < 0 || tbl_vuid[hit] != it.endpoint_vuid ||
					tbl_flags[hit] != it.access_flags) begin
				r.status = ST_NO_MATCH;
				n_nomatch++;
				return r;
			end
			r.handle_out = tbl_handle[hit];
			if (tbl_refs[hit] > 1) begin
				tbl_refs[hit]--;
			end else begin
				tbl_valid[hit] = 1'b0;
				if (freed_ids.size() < DEPTH)
					freed_ids.push_back(tbl_id[hit]);
				r.entry_freed = 1'b1;
				n_freed++;
			end
		end
		return r;
	endfunction

	task automatic push_item(logic op, logic [31:0] h, logic [31:0] f, logic [63:0] v,
			logic [31:0] id);
		in_item_t it;
		it.operation = op;
		it.buffer_handle = h;
		it.access_flags = f;
		it.endpoint_vuid = v;
		it.share_id_in = id;
		pending_items.push_back(it);
		awaited_results.push_back(share_table_predict(it));
	endtask

	function automatic int pick_live_slot();
		int live [$];
		for (int i = 0; i < DEPTH; i++)
			if (tbl_valid[i])
				live.push_back(i);
		if (live.size() == 0)
			return -1;
		return live[$urandom_range(0, live.size() - 1)];
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic report(string what, out_item_t got, out_item_t want);
		errors++;
		$display("mismatch on %s at result %0d: got %h want %h", what, received, got, want);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	// sender: one gap draw per item, no gaps in the quiet window
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			in_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				sent++;
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_items.size() != 0) begin
				in_item <= pending_items.pop_front();
				in_valid <= 1'b1;
				in_gap <= (sent > 500 && sent < 650) ? 0 : $urandom_range(0, 9);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: one stall draw per item, plus one long hold-off
	int out_stall;
	always @(posedge clk or negedge arst_n) begin
		int n;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else if (out_valid && out_ready) begin
			if (received == 300)
				n = 600;
			else if (received > 500 && received < 650)
				n = 0;
			else
				n = $urandom_range(0, 9);
			out_stall <= n;
			out_ready <= (n == 0);
		end else if (out_stall != 0) begin
			out_stall <= out_stall - 1;
			out_ready <= (out_stall == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				errors++;
				$display("result %0d arrived with nothing outstanding", received);
			end else begin
				want = awaited_results.pop_front();
				if (out_item.status !== want.status)
					report("status", out_item, want);
				if (out_item.share_id_out !== want.share_id_out)
					report("share_id_out", out_item, want);
				if (out_item.handle_out !== want.handle_out)
					report("handle_out", out_item, want);
				if (out_item.entry_freed !== want.entry_freed)
					report("entry_freed", out_item, want);
			end
			received++;
		end
	end

	initial begin
		int s;
		int r;
		logic [31:0] f;
		logic [63:0] v;
		for (int i = 0; i < DEPTH; i++)
			tbl_valid[i] = 1'b0;
		last_counter_id = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, hits, misses, reuse of a freed id, multi-ref redeem
		push_item(OP_CREATE, 32'd0, 32'd0, 64'd0, 32'hFFFF_FFFF);
		push_item(OP_CREATE, '1, '1, '1, 32'd0);
		push_item(OP_CREATE, '1, '1, '1, 32'd5);
		push_item(OP_REDEEM, '1, 32'd0, 64'd0, 32'd2);
		push_item(OP_REDEEM, 32'd0, 32'h1, '1, 32'd4);
		push_item(OP_REDEEM, 32'd0, '1, 64'h1, 32'd4);
		push_item(OP_REDEEM, 32'd0, '1, '1, 32'hFFFF_FFFF);
		push_item(OP_REDEEM, 32'd0, '1, '1, 32'd0);
		push_item(OP_CREATE, 32'h1234_5678, 32'h8000_0001, 64'h8000_0000_0000_0001, 32'd0);
		push_item(OP_REDEEM, 32'd0, '1, '1, 32'd4);
		push_item(OP_REDEEM, 32'd0, '1, '1, 32'd4);
		push_item(OP_REDEEM, 32'd0, '1, '1, 32'd4);
		push_item(OP_REDEEM, 32'd7, 32'h8000_0001, 64'h8000_0000_0000_0001, 32'd2);

		// fill the table, overflow it, then drain it
		for (int i = 0; i < DEPTH + 3; i++)
			push_item(OP_CREATE, $urandom, $urandom, {$urandom, $urandom}, $urandom);
		while ((s = pick_live_slot()) >= 0)
			push_item(OP_REDEEM, $urandom, tbl_flags[s], tbl_vuid[s], tbl_id[s]);

		// random: mostly well-formed traffic on live entries, some corrupted lookups
		for (int k = 0; k < 956; k++) begin
			r = $urandom_range(0, 99);
			s = pick_live_slot();
			if (r < 35 || s < 0) begin
				push_item(OP_CREATE, rand_word(), rand_word(), {rand_word(), rand_word()},
					$urandom);
			end else if (r < 55) begin
				push_item(OP_CREATE, tbl_handle[s], tbl_flags[s], tbl_vuid[s], $urandom);
			end else if (r < 85) begin
				push_item(OP_REDEEM, $urandom, tbl_flags[s], tbl_vuid[s], tbl_id[s]);
			end else if (r < 93) begin
				f = tbl_flags[s];
				v = tbl_vuid[s];
				if ($urandom_range(0, 1))
					f[$urandom_range(0, 31)] ^= 1'b1;
				else
					v[$urandom_range(0, 63)] ^= 1'b1;
				push_item(OP_REDEEM, $urandom, f, v, tbl_id[s]);
			end else begin
				push_item(OP_REDEEM, $urandom, rand_word(), {$urandom, $urandom}, rand_word());
			end
		end

		while (pending_items.size() != 0 || awaited_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d items sent, %0d results checked", sent, received);
		$display("%0d key hits, %0d freed entries, %0d lookup misses, %0d table full",
			n_hits, n_freed, n_nomatch, n_full);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

FILE: files.f
design/rsit_pkg.sv
design/rsit_datapath.sv
design/rsit_ctrl.sv
design/refcounted_share_id_table.sv
tb/testbench.sv
